// ===== sv/ffba_pkg.sv =====
// ----------------------------------------------------------------------------
// ffba_pkg
// Types and constants shared by the first-fit block allocator modules.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int unsigned MaxEntries = 64;
  localparam int unsigned OfsW       = 32;
  localparam int unsigned IdxW       = $clog2(MaxEntries);
  localparam int unsigned CntW       = $clog2(MaxEntries + 1);

  localparam logic [OfsW-1:0] AlignMask  = OfsW'(255);
  localparam logic [OfsW-1:0] SplitSlack = OfsW'(1024);
  localparam logic [OfsW-1:0] PoolReset  = OfsW'(1073741824);

  typedef enum logic [1:0] {
    FUNC_ALLOC  = 2'd0,
    FUNC_FREE   = 2'd1,
    FUNC_DEFRAG = 2'd2,
    FUNC_REINIT = 2'd3
  } func_e;

  typedef struct packed {
    logic            busy;
    logic [OfsW-1:0] size;
    logic [OfsW-1:0] base;
  } entry_t;

  typedef struct packed {
    func_e       func;
    logic [31:0] request_bytes;
    logic [31:0] block_address;
  } req_t;

  typedef struct packed {
    logic            ok;
    logic [31:0]     granted_address;
    logic [31:0]     available_bytes;
    logic [CntW-1:0] entry_count;
  } rsp_t;

  typedef struct packed {
    logic            rd_en;
    logic [IdxW-1:0] rd_addr;
    logic            wr_en;
    logic [IdxW-1:0] wr_addr;
    entry_t          wr_data;
  } mreq_t;

endpackage

// ===== sv/ffba_mem.sv =====
// ----------------------------------------------------------------------------
// ffba_mem
// Block table memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ffba_mem import ffba_pkg::*; (
  input  logic   clk_i,
  input  mreq_t  req_i,
  output entry_t rdata_o
);

  entry_t mem [MaxEntries];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem[req_i.rd_addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/ffba_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffba_ctrl
// Sequencer: scans, sorts, merges, reinitialises and sums the block table in memory.
// ----------------------------------------------------------------------------
module ffba_ctrl import ffba_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [OfsW-1:0] pool_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  req_t            in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output rsp_t            out_data_o,
  output mreq_t           mreq_o,
  input  entry_t          rdata_i
);

  typedef enum logic [12:0] {
    S_BOOT      = 13'b0000000000001,
    S_IDLE      = 13'b0000000000010,
    S_ALLOC     = 13'b0000000000100,
    S_SPLIT     = 13'b0000000001000,
    S_FREE      = 13'b0000000010000,
    S_INIT      = 13'b0000000100000,
    S_SORT_LD   = 13'b0000001000000,
    S_SORT_HOLD = 13'b0000010000000,
    S_SORT_CMP  = 13'b0000100000000,
    S_SORT_PUT  = 13'b0001000000000,
    S_MERGE     = 13'b0010000000000,
    S_SUM       = 13'b0100000000000,
    S_DONE      = 13'b1000000000000
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d, rk_q, rk_d, i_q, i_d;
  logic            pv_q, pv_d;
  logic [IdxW-1:0] pi_q, pi_d, j_q, j_d, w_q, w_d;
  logic [OfsW:0]   need_q, need_d, need_w;
  logic [OfsW-1:0] addr_q, addr_d, gnt_q, gnt_d, acc_q, acc_d, accb;
  entry_t          held_q, held_d;
  logic            ok_q, ok_d, ov_q, ov_d;
  rsp_t            rsp_q, rsp_d;
  logic            issue, split;
  logic [OfsW:0]   sum_w, msum_w;
  mreq_t           mreq;

  assign issue  = rk_q < cnt_q;
  assign need_w = ({1'b0, in_data_i.request_bytes} + {1'b0, AlignMask}) & ~{1'b0, AlignMask};
  assign split  = ({2'b0, rdata_i.size} > ({1'b0, need_q} + {2'b0, SplitSlack}))
                  && (cnt_q < CntW'(MaxEntries));
  assign accb   = (pi_q == '0) ? '0 : acc_q;
  assign sum_w  = {1'b0, accb} + {1'b0, rdata_i.size};
  assign msum_w = {1'b0, held_q.size} + {1'b0, rdata_i.size};

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    rk_d    = rk_q;
    pv_d    = 1'b0;
    pi_d    = pi_q;
    i_d     = i_q;
    j_d     = j_q;
    w_d     = w_q;
    need_d  = need_q;
    addr_d  = addr_q;
    gnt_d   = gnt_q;
    acc_d   = acc_q;
    held_d  = held_q;
    ok_d    = ok_q;
    ov_d    = ov_q && !out_ready_i;
    rsp_d   = rsp_q;
    mreq    = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_BOOT: begin
        mreq.wr_en   = 1'b1;
        mreq.wr_data = '{busy: 1'b0, size: pool_i, base: '0};
        cnt_d        = CntW'(1);
        state_d      = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ok_d  = 1'b1;
          gnt_d = '0;
          rk_d  = '0;
          unique case (in_data_i.func)
            FUNC_ALLOC: begin
              need_d = need_w;
              if (need_w[OfsW]) begin
                ok_d    = 1'b0;
                state_d = S_SUM;
              end else begin
                state_d = S_ALLOC;
              end
            end
            FUNC_FREE: begin
              addr_d  = in_data_i.block_address;
              state_d = S_FREE;
            end
            FUNC_DEFRAG: begin
              i_d     = CntW'(1);
              state_d = S_SORT_LD;
            end
            default: state_d = S_INIT;
          endcase
        end
      end
      S_ALLOC: begin
        mreq.rd_en   = issue;
        mreq.rd_addr = rk_q[IdxW-1:0];
        pv_d = issue;
        pi_d = rk_q[IdxW-1:0];
        rk_d = rk_q + CntW'(issue);
        if (pv_q && !rdata_i.busy && rdata_i.size >= need_q[OfsW-1:0]) begin
          gnt_d        = rdata_i.base;
          mreq.wr_en   = 1'b1;
          mreq.wr_addr = pi_q;
          mreq.wr_data = '{busy: 1'b1, size: split ? need_q[OfsW-1:0] : rdata_i.size,
                           base: rdata_i.base};
          held_d = '{busy: 1'b0, size: rdata_i.size - need_q[OfsW-1:0],
                     base: rdata_i.base + need_q[OfsW-1:0]};
          rk_d    = '0;
          pv_d    = 1'b0;
          state_d = split ? S_SPLIT : S_SUM;
        end else if (!pv_q && !issue) begin
          ok_d    = 1'b0;
          rk_d    = '0;
          state_d = S_SUM;
        end
      end
      S_SPLIT: begin
        mreq.wr_en   = 1'b1;
        mreq.wr_addr = cnt_q[IdxW-1:0];
        mreq.wr_data = held_q;
        cnt_d        = cnt_q + CntW'(1);
        state_d      = S_SUM;
      end
      S_FREE: begin
        mreq.rd_en   = issue;
        mreq.rd_addr = rk_q[IdxW-1:0];
        pv_d = issue;
        pi_d = rk_q[IdxW-1:0];
        rk_d = rk_q + CntW'(issue);
        if (pv_q && rdata_i.base == addr_q) begin
          mreq.wr_en   = 1'b1;
          mreq.wr_addr = pi_q;
          mreq.wr_data = '{busy: 1'b0, size: rdata_i.size, base: rdata_i.base};
          rk_d    = '0;
          pv_d    = 1'b0;
          state_d = S_SUM;
        end else if (!pv_q && !issue) begin
          rk_d    = '0;
          state_d = S_SUM;
        end
      end
      S_INIT: begin
        mreq.wr_en   = 1'b1;
        mreq.wr_data = '{busy: 1'b0, size: pool_i, base: '0};
        cnt_d        = CntW'(1);
        state_d      = S_SUM;
      end
      S_SORT_LD: begin
        if (i_q >= cnt_q) begin
          rk_d    = '0;
          state_d = S_MERGE;
        end else begin
          mreq.rd_en   = 1'b1;
          mreq.rd_addr = i_q[IdxW-1:0];
          state_d      = S_SORT_HOLD;
        end
      end
      S_SORT_HOLD: begin
        held_d       = rdata_i;
        j_d          = i_q[IdxW-1:0];
        mreq.rd_en   = 1'b1;
        mreq.rd_addr = i_q[IdxW-1:0] - IdxW'(1);
        state_d      = S_SORT_CMP;
      end
      S_SORT_CMP: begin
        mreq.wr_en   = 1'b1;
        mreq.wr_addr = j_q;
        if (rdata_i.base > held_q.base) begin
          mreq.wr_data = rdata_i;
          j_d          = j_q - IdxW'(1);
          if (j_q == IdxW'(1)) begin
            state_d = S_SORT_PUT;
          end else begin
            mreq.rd_en   = 1'b1;
            mreq.rd_addr = j_q - IdxW'(2);
          end
        end else begin
          mreq.wr_data = held_q;
          i_d          = i_q + CntW'(1);
          state_d      = S_SORT_LD;
        end
      end
      S_SORT_PUT: begin
        mreq.wr_en   = 1'b1;
        mreq.wr_data = held_q;
        i_d          = i_q + CntW'(1);
        state_d      = S_SORT_LD;
      end
      S_MERGE: begin
        mreq.rd_en   = issue;
        mreq.rd_addr = rk_q[IdxW-1:0];
        pv_d = issue;
        pi_d = rk_q[IdxW-1:0];
        rk_d = rk_q + CntW'(issue);
        if (pv_q) begin
          if (pi_q == '0) begin
            held_d = rdata_i;
            w_d    = '0;
          end else if (!held_q.busy && !rdata_i.busy &&
                       ({1'b0, held_q.base} + {1'b0, held_q.size}) == {1'b0, rdata_i.base}) begin
            held_d.size = msum_w[OfsW] ? '1 : msum_w[OfsW-1:0];
          end else begin
            mreq.wr_en   = 1'b1;
            mreq.wr_addr = w_q;
            mreq.wr_data = held_q;
            w_d          = w_q + IdxW'(1);
            held_d       = rdata_i;
          end
        end else if (!issue) begin
          mreq.wr_en   = 1'b1;
          mreq.wr_addr = w_q;
          mreq.wr_data = held_q;
          cnt_d        = CntW'(w_q) + CntW'(1);
          rk_d         = '0;
          state_d      = S_SUM;
        end
      end
      S_SUM: begin
        mreq.rd_en   = issue;
        mreq.rd_addr = rk_q[IdxW-1:0];
        pv_d = issue;
        pi_d = rk_q[IdxW-1:0];
        rk_d = rk_q + CntW'(issue);
        if (pv_q) begin
          acc_d = rdata_i.busy ? accb : (sum_w[OfsW] ? '1 : sum_w[OfsW-1:0]);
        end else if (!issue) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!ov_q || out_ready_i) begin
          ov_d    = 1'b1;
          rsp_d   = '{ok: ok_q, granted_address: gnt_q, available_bytes: acc_q,
                      entry_count: cnt_q};
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_BOOT;
      cnt_q   <= CntW'(1);
      rk_q    <= '0;
      pv_q    <= 1'b0;
      i_q     <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rk_q    <= rk_d;
      pv_q    <= pv_d;
      i_q     <= i_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pi_q   <= pi_d;
    j_q    <= j_d;
    w_q    <= w_d;
    need_q <= need_d;
    addr_q <= addr_d;
    gnt_q  <= gnt_d;
    acc_q  <= acc_d;
    held_q <= held_d;
    ok_q   <= ok_d;
    rsp_q  <= rsp_d;
  end

  assign mreq_o      = mreq;
  assign out_valid_o = ov_q;
  assign out_data_o  = rsp_q;

`ifndef NO_ASSERTIONS
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mreq.rd_en && mreq.wr_en |-> mreq.rd_addr != mreq.wr_addr)
    else $error("read and write of one entry in the same cycle");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q >= CntW'(1) && cnt_q <= CntW'(MaxEntries))
    else $error("entry count out of range");
  a_wr_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mreq.wr_en |-> CntW'(mreq.wr_addr) <= cnt_q)
    else $error("write beyond the end of the table");
`endif

endmodule

// ===== sv/first_fit_block_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// first_fit_block_allocator_unit
// First-fit allocator over a block table of base, size and busy entries.
//
//   channel  signals                            beat
//   in       in_valid_i / in_ready_o            req_t: func, request, address
//   out      out_valid_o / out_ready_i          rsp_t: ok, address, free, count
//   cfg      cfg_valid_i / cfg_ready_o          pool size in bytes
//
// One item at a time. Allocate and free scan the table one entry a cycle, then
// a summing pass reads every entry again before the result is given.
// Defragment insertion-sorts the entries by base in memory, then runs merge
// and summing passes. The unit returns to idle before it accepts an item.
// After reset a boot state writes the first entry before in_ready_o.
// A result waiting on out_ready_i stalls only the next result, not the input.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_unit import ffba_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  req_t        in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output rsp_t        out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);

  logic [OfsW-1:0] pool_q;
  mreq_t           mreq;
  entry_t          rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_q <= PoolReset;
    end else if (cfg_valid_i) begin
      pool_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  ffba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pool_i      (pool_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .mreq_o      (mreq),
    .rdata_i     (rdata)
  );

  ffba_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mreq),
    .rdata_o (rdata)
  );

endmodule
